FILE: rtl/ntcpl_pkg.sv
package ntcpl_pkg;

  localparam int ADC_BITS  = 12;
  localparam int FRAC_BITS = 8;

  localparam int CODE_W    = 12;
  localparam int BP_W      = 12;
  localparam int NUM_BP    = 7;
  localparam int CFG_IDX_W = 3;
  localparam int SEG_W     = 3;
  localparam int OUT_W     = 17;

  localparam int CENTER_CODE = 256;
  localparam int TOP_DEG     = 175;
  localparam int STEP_DEG    = 25;
  localparam int BASE_DEG    = 5;
  localparam int DEG_W       = 8;

  localparam int PROD_W    = BP_W + 5;
  localparam int NUM_MAG_W = PROD_W + FRAC_BITS;
  localparam int DEN_W     = BP_W;
  localparam int BASE_W    = DEG_W + FRAC_BITS;
  localparam int VAL_W     = NUM_MAG_W + 2;
  localparam int DIV_STEPS = NUM_MAG_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QPTR_W + 1;

  localparam logic [CODE_W-1:0] CODE_MASK = CODE_W'((64'd1 << ADC_BITS) - 64'd1);

  localparam logic [BP_W-1:0] BP_RESET [NUM_BP] = '{
    12'd0, 12'd600, 12'd1200, 12'd1800, 12'd2400, 12'd3000, 12'd3600
  };

  localparam logic signed [VAL_W-1:0] OUT_MAX = VAL_W'((64'd1 << (OUT_W - 1)) - 64'd1);
  localparam logic signed [VAL_W-1:0] OUT_MIN = -VAL_W'(64'd1 << (OUT_W - 1));

  typedef struct packed {
    logic [DEN_W-1:0]     rem;
    logic [NUM_MAG_W-1:0] nq;
    logic [DEN_W-1:0]     den;
    logic                 neg;
    logic                 flat;
    logic                 above;
    logic [BASE_W-1:0]    base;
  } work_t;

  // one restoring step: shift in a numerator bit, subtract when it fits
  function automatic work_t div_step(work_t w);
    logic [DEN_W:0] t;
    logic [DEN_W:0] d;
    work_t          o;
    o = w;
    t = {w.rem, w.nq[NUM_MAG_W-1]};
    d = {1'b0, w.den};
    if (t >= d) begin
      o.rem = DEN_W'(t - d);
      o.nq  = {w.nq[NUM_MAG_W-2:0], 1'b1};
    end else begin
      o.rem = t[DEN_W-1:0];
      o.nq  = {w.nq[NUM_MAG_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

FILE: rtl/ntcpl_front.sv
module ntcpl_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [ntcpl_pkg::CODE_W-1:0]      adc_code,
  input  logic                              cfg_wr,
  input  logic [ntcpl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ntcpl_pkg::BP_W-1:0]        cfg_data,
  output logic                              q_push,
  output ntcpl_pkg::work_t                  q_wdata,
  input  logic                              q_full
);

  logic [ntcpl_pkg::BP_W-1:0] bp [ntcpl_pkg::NUM_BP];

  logic                       fv;
  ntcpl_pkg::work_t           fw;
  ntcpl_pkg::work_t           fw_next;
  logic                       front_ready;
  logic                       accept;

  logic [ntcpl_pkg::CODE_W-1:0] code;
  logic [ntcpl_pkg::BP_W-1:0]   r;
  logic [ntcpl_pkg::SEG_W-1:0]  k;
  logic [ntcpl_pkg::BP_W-1:0]   lo;
  logic [ntcpl_pkg::BP_W-1:0]   hi;
  logic signed [ntcpl_pkg::BP_W:0] dn;
  logic signed [ntcpl_pkg::BP_W:0] dd;
  logic [ntcpl_pkg::BP_W-1:0]   dn_mag;
  logic [ntcpl_pkg::BP_W-1:0]   dd_mag;
  logic [ntcpl_pkg::PROD_W-1:0] prod;
  logic                         above;
  logic [ntcpl_pkg::DEG_W-1:0]  deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ntcpl_pkg::NUM_BP; i++) begin
        bp[i] <= ntcpl_pkg::BP_RESET[i];
      end
    end else if (cfg_wr && (cfg_index < ntcpl_pkg::CFG_IDX_W'(ntcpl_pkg::NUM_BP))) begin
      bp[cfg_index] <= cfg_data;
    end
  end

  always_comb begin
    code = adc_code & ntcpl_pkg::CODE_MASK;
    if (code >= ntcpl_pkg::CODE_W'(ntcpl_pkg::CENTER_CODE)) begin
      r = ntcpl_pkg::BP_W'(code - ntcpl_pkg::CODE_W'(ntcpl_pkg::CENTER_CODE));
    end else begin
      r = ntcpl_pkg::BP_W'(ntcpl_pkg::CODE_W'(ntcpl_pkg::CENTER_CODE) - code);
    end
    above = (r >= bp[ntcpl_pkg::NUM_BP-1]);

    // lowest i with r below breakpoint i picks segment i-1
    k = ntcpl_pkg::SEG_W'(ntcpl_pkg::NUM_BP - 2);
    for (int i = ntcpl_pkg::NUM_BP - 1; i >= 1; i--) begin
      if (r < bp[i]) begin
        k = ntcpl_pkg::SEG_W'(i - 1);
      end
    end
    lo = bp[k];
    hi = bp[ntcpl_pkg::SEG_W'(k + 1'b1)];
    dn = $signed({1'b0, r}) - $signed({1'b0, lo});
    dd = $signed({1'b0, hi}) - $signed({1'b0, lo});
    dn_mag = dn[ntcpl_pkg::BP_W] ? ntcpl_pkg::BP_W'(-dn) : dn[ntcpl_pkg::BP_W-1:0];
    dd_mag = dd[ntcpl_pkg::BP_W] ? ntcpl_pkg::BP_W'(-dd) : dd[ntcpl_pkg::BP_W-1:0];
    prod = ntcpl_pkg::PROD_W'(dn_mag) * ntcpl_pkg::PROD_W'(ntcpl_pkg::STEP_DEG);

    if (above) begin
      deg = ntcpl_pkg::DEG_W'(ntcpl_pkg::TOP_DEG);
    end else begin
      deg = ntcpl_pkg::DEG_W'(ntcpl_pkg::DEG_W'(k) * ntcpl_pkg::DEG_W'(ntcpl_pkg::STEP_DEG)
                              + ntcpl_pkg::DEG_W'(ntcpl_pkg::BASE_DEG));
    end

    fw_next.rem   = '0;
    fw_next.nq    = {prod, {ntcpl_pkg::FRAC_BITS{1'b0}}};
    fw_next.den   = dd_mag;
    fw_next.neg   = dn[ntcpl_pkg::BP_W] ^ dd[ntcpl_pkg::BP_W];
    fw_next.flat  = !above && (dd == '0);
    fw_next.above = above;
    fw_next.base  = {deg, {ntcpl_pkg::FRAC_BITS{1'b0}}};
  end

  assign front_ready = !fv || !q_full;
  assign full        = !front_ready;
  assign accept      = push && front_ready;
  assign q_push      = fv && !q_full;
  assign q_wdata     = fw;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (front_ready) begin
      fv <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      fw <= fw_next;
    end
  end

endmodule

FILE: rtl/ntcpl_queue.sv
module ntcpl_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  ntcpl_pkg::work_t wdata,
  output logic             full,
  input  logic             pop,
  output ntcpl_pkg::work_t rdata,
  output logic             empty
);

  ntcpl_pkg::work_t                 slots [ntcpl_pkg::QUEUE_DEPTH];
  logic [ntcpl_pkg::QPTR_W-1:0]     head;
  logic [ntcpl_pkg::QPTR_W-1:0]     tail;
  logic [ntcpl_pkg::QCNT_W-1:0]     count;
  logic                             do_push;
  logic                             do_pop;

  assign full    = (count == ntcpl_pkg::QCNT_W'(ntcpl_pkg::QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[head];

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        tail <= tail + 1'b1;
      end
      if (do_pop) begin
        head <= head + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[tail] <= wdata;
    end
  end

endmodule

FILE: rtl/ntcpl_back.sv
module ntcpl_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_empty,
  input  ntcpl_pkg::work_t                    q_rdata,
  output logic                                q_pop,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [ntcpl_pkg::OUT_W-1:0]  temperature_q8,
  output logic                                saturated,
  output logic                                above_table,
  output logic                                flat_segment
);

  logic             sv [ntcpl_pkg::DIV_STEPS];
  ntcpl_pkg::work_t sw [ntcpl_pkg::DIV_STEPS];
  logic             ov;
  logic             adv;

  ntcpl_pkg::work_t                   w;
  logic signed [ntcpl_pkg::VAL_W-1:0] qs;
  logic signed [ntcpl_pkg::VAL_W-1:0] val;
  logic signed [ntcpl_pkg::OUT_W-1:0] temp_next;
  logic                               sat_next;

  assign adv   = !ov || pop;
  assign q_pop = adv && !q_empty;
  assign empty = !ov;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ntcpl_pkg::DIV_STEPS; i++) begin
        sv[i] <= 1'b0;
      end
      ov <= 1'b0;
    end else if (adv) begin
      sv[0] <= q_pop;
      for (int i = 1; i < ntcpl_pkg::DIV_STEPS; i++) begin
        sv[i] <= sv[i-1];
      end
      ov <= sv[ntcpl_pkg::DIV_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sw[0] <= ntcpl_pkg::div_step(q_rdata);
      for (int i = 1; i < ntcpl_pkg::DIV_STEPS; i++) begin
        sw[i] <= ntcpl_pkg::div_step(sw[i-1]);
      end
    end
  end

  // floor: a nonzero remainder with unlike signs rounds one further down
  always_comb begin
    w = sw[ntcpl_pkg::DIV_STEPS-1];
    if (w.neg) begin
      qs = -($signed(ntcpl_pkg::VAL_W'(w.nq)) +
             $signed(ntcpl_pkg::VAL_W'(w.rem != '0)));
    end else begin
      qs = $signed(ntcpl_pkg::VAL_W'(w.nq));
    end
    val = $signed(ntcpl_pkg::VAL_W'(w.base));
    if (!w.above && !w.flat) begin
      val = val + qs;
    end
    sat_next = 1'b0;
    if (val > ntcpl_pkg::OUT_MAX) begin
      temp_next = ntcpl_pkg::OUT_MAX[ntcpl_pkg::OUT_W-1:0];
      sat_next  = 1'b1;
    end else if (val < ntcpl_pkg::OUT_MIN) begin
      temp_next = ntcpl_pkg::OUT_MIN[ntcpl_pkg::OUT_W-1:0];
      sat_next  = 1'b1;
    end else begin
      temp_next = val[ntcpl_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      temperature_q8 <= temp_next;
      saturated      <= sat_next;
      above_table    <= w.above;
      flat_segment   <= w.flat;
    end
  end

endmodule

FILE: rtl/ntc_piecewise_linearizer.sv
// channel  | direction | handshake           | word
// ---------+-----------+---------------------+------------------------------------------
// input    | in        | push / full         | adc_code
// result   | out       | pop / empty         | temperature_q8, saturated, above_table,
//          |           |                     | flat_segment
// config   | in        | cfg_wr (no stall)   | cfg_index, cfg_data
//
// One word per cycle sustained while no result is held; from push to empty low a word passes
// one front register, the queue, 25 restoring divider stages (one quotient bit each)
// and the output register. Synchronous active-high rst clears control and loads the
// default breakpoints. A held result stalls the divider pipeline; the queue then fills
// and full rises.
module ntc_piecewise_linearizer (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [ntcpl_pkg::CODE_W-1:0]        adc_code,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [ntcpl_pkg::OUT_W-1:0]  temperature_q8,
  output logic                                saturated,
  output logic                                above_table,
  output logic                                flat_segment,
  input  logic                                cfg_wr,
  input  logic [ntcpl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ntcpl_pkg::BP_W-1:0]          cfg_data
);

  logic             q_push;
  logic             q_full;
  logic             q_pop;
  logic             q_empty;
  ntcpl_pkg::work_t q_wdata;
  ntcpl_pkg::work_t q_rdata;

  ntcpl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .adc_code  (adc_code),
    .cfg_wr    (cfg_wr),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_push    (q_push),
    .q_wdata   (q_wdata),
    .q_full    (q_full)
  );

  ntcpl_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  ntcpl_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_rdata        (q_rdata),
    .q_pop          (q_pop),
    .empty          (empty),
    .pop            (pop),
    .temperature_q8 (temperature_q8),
    .saturated      (saturated),
    .above_table    (above_table),
    .flat_segment   (flat_segment)
  );

endmodule
